>>> hdl/htbm_pkg.sv
`timescale 1ns / 1ps

package htbm_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam int REQ_W   = 2;
  localparam int ITEM_W  = 16;
  localparam int SUM_W   = 48;
  localparam int TOTAL_W = 17;
  localparam int MBINS_W = 17;

  localparam logic [MBINS_W-1:0] MAX_BINS_RESET = 17'h10000;
  localparam logic [SUM_W-1:0]   SUM_MAX        = {SUM_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ITEM_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [SUM_W-1:0]   bin_count;
    logic [TOTAL_W-1:0] bin_total;
    logic               index_valid;
  } out_word_t;

endpackage

>>> hdl/htbm_div.sv
`timescale 1ns / 1ps

module htbm_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[DEN_W+1]) begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> hdl/histogram_trim_and_bin_merge.sv
`timescale 1ns / 1ps
// Add word: in_ready returns after the bin is read, then written back (S_ADD_RD, S_ADD_WR).
// Read word: the bins of the group are read one at a time; merging adds two serial
// divisions. A held result word stalls the end.
// Clear word: a sweep over all 2^VALUE_BITS entries of the bin memory, one entry per cycle.
// After reset the same sweep runs before the first word is taken; config writes are taken in
// every cycle outside reset. max_bins resets to 65536.
module histogram_trim_and_bin_merge #(
  parameter int VALUE_BITS = htbm_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = htbm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  htbm_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output htbm_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htbm_pkg::MBINS_W-1:0]    cfg_data
);

  import htbm_pkg::*;

  localparam int DEPTH = 1 << VALUE_BITS;
  localparam int LEN_W = VALUE_BITS + 1;
  localparam int DIV_W = (LEN_W > MBINS_W) ? LEN_W : MBINS_W;
  localparam int NUM_W = DIV_W + 1;
  localparam int XW    = (VALUE_BITS > ITEM_W) ? VALUE_BITS : ITEM_W;
  localparam int SXW   = ((COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W) + 1;
  localparam int PRD_W = ITEM_W + DIV_W;

  typedef enum logic [9:0] {
    S_CLR     = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_ADD_RD  = 10'b0000000100,
    S_ADD_WR  = 10'b0000001000,
    S_DIV1    = 10'b0000010000,
    S_DIV2    = 10'b0000100000,
    S_MUL     = 10'b0001000000,
    S_SUM_RD  = 10'b0010000000,
    S_SUM_ACC = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [LEN_W-1:0]      trim_r, trim_nxt;
  logic [MBINS_W-1:0]    max_bins_r;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic [ITEM_W-1:0]     item_r, item_nxt;
  logic [VALUE_BITS-1:0] addr_r, addr_nxt;
  logic [DIV_W-1:0]      group_r, group_nxt;
  logic [DIV_W-1:0]      total_r, total_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic [DIV_W-1:0]      j_r, j_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  idx_valid_r, idx_valid_nxt;
  logic [COUNT_BITS-1:0] rd_data_r;

  logic                  mem_we, mem_re;
  logic [VALUE_BITS-1:0] mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic                  accept;
  logic [XW-1:0]         item_x;
  logic [VALUE_BITS-1:0] sample;
  logic [LEN_W-1:0]      sample_len;
  logic [DIV_W-1:0]      m_eff, len_x;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num, div_quo;
  logic [DIV_W-1:0]      div_den;
  logic [PRD_W-1:0]      prod;
  logic [SXW-1:0]        sum_ext;

  // The register only takes a word while the block is out of reset.
  assign cfg_ready = rst_n;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign item_x     = XW'(in_data.item_value);
  assign sample     = item_x[VALUE_BITS-1:0];
  assign sample_len = LEN_W'(sample) + 1'b1;

  // A max_bins of zero behaves as one.
  assign m_eff = (max_bins_r == '0) ? DIV_W'(1) : DIV_W'(max_bins_r);
  assign len_x = DIV_W'(trim_r);

  // For a read with L > M, the divider first finds the group size ceil(L/M), then the total ceil(L/group).
  always_comb begin
    if (state_r == S_IDLE) begin
      div_num = NUM_W'(len_x) + NUM_W'(m_eff) - 1'b1;
      div_den = m_eff;
    end else begin
      div_num = NUM_W'(len_x) + NUM_W'(div_quo[DIV_W-1:0]) - 1'b1;
      div_den = div_quo[DIV_W-1:0];
    end
  end

  assign prod    = PRD_W'(item_r) * PRD_W'(group_r);
  assign sum_ext = SXW'(sum_r) + SXW'(rd_data_r);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    trim_nxt      = trim_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    item_nxt      = item_r;
    addr_nxt      = addr_r;
    group_nxt     = group_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    sum_nxt       = sum_r;
    idx_valid_nxt = idx_valid_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_r;
    mem_raddr     = addr_r;
    mem_wdata     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {VALUE_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data.item_value;
          case (in_data.req_type)
            REQ_ADD: begin
              addr_nxt = sample;
              if (sample_len > trim_r) begin
                trim_nxt = sample_len;
              end
              state_nxt = S_ADD_RD;
            end
            REQ_READ: begin
              if (len_x > m_eff) begin
                div_start = 1'b1;
                state_nxt = S_DIV1;
              end else begin
                group_nxt = DIV_W'(1);
                total_nxt = len_x;
                state_nxt = S_MUL;
              end
            end
            REQ_CLEAR: begin
              trim_nxt     = '0;
              clr_addr_nxt = '0;
              state_nxt    = S_CLR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_data_r == {COUNT_BITS{1'b1}}) ? rd_data_r : rd_data_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV1: begin
        if (div_done) begin
          group_nxt = div_quo[DIV_W-1:0];
          div_start = 1'b1;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          total_nxt = div_quo[DIV_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        idx_valid_nxt = DIV_W'(item_r) < total_r;
        pos_nxt       = prod[LEN_W-1:0];
        j_nxt         = '0;
        sum_nxt       = '0;
        state_nxt     = (DIV_W'(item_r) < total_r) ? S_SUM_RD : S_OUT;
      end
      S_SUM_RD: begin
        // The last group may run past the trimmed length.
        if (j_r == group_r || pos_r >= trim_r) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_r[VALUE_BITS-1:0];
          state_nxt = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        if (sum_ext > SXW'(SUM_MAX)) begin
          sum_nxt   = SUM_MAX;
          state_nxt = S_OUT;
        end else begin
          sum_nxt   = sum_ext[SUM_W-1:0];
          j_nxt     = j_r + 1'b1;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.bin_count   = sum_r;
          out_data_nxt.bin_total   = total_r[TOTAL_W-1:0];
          out_data_nxt.index_valid = idx_valid_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  htbm_div #(
    .NUM_W(NUM_W),
    .DEN_W(DIV_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      trim_r      <= '0;
      max_bins_r  <= MAX_BINS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      trim_r      <= trim_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_bins_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    item_r      <= item_nxt;
    addr_r      <= addr_nxt;
    group_r     <= group_nxt;
    total_r     <= total_nxt;
    pos_r       <= pos_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    idx_valid_r <= idx_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/htbm_check.sv
`timescale 1ns / 1ps

module htbm_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input htbm_pkg::in_word_t           in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input htbm_pkg::out_word_t          out_data
);

  import htbm_pkg::*;

  // A result word that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An out-of-range read carries a zero count.
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.index_valid |-> out_data.bin_count == '0)
    else $error("out-of-range read with nonzero count");

  // A valid index needs a nonempty histogram.
  a_valid_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_valid |-> out_data.bin_total != '0)
    else $error("valid index with zero bin total");

  // Reset starts the clearing sweep with nothing pending.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready or result pending right after reset");

  // A clear word starts the sweep at once.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_CLEAR |=> !in_ready)
    else $error("block ready right after a clear word");

endmodule

bind histogram_trim_and_bin_merge htbm_check u_htbm_check (.*);
